// ===== src/maprng_pkg.sv =====
// Shared types, constants and helper functions for the mixing-array PRNG.
package maprng_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumWords = 10;
  localparam int unsigned MixSteps = 10;
  localparam int unsigned StepCntW = $clog2(MixSteps);
  localparam int unsigned WinSelW  = 3;

  // The state words are held in a ring that is always parked with word 3 at
  // position 0, so word n sits at position (n + 7) mod 10.
  localparam int unsigned RingOfs = 7;

  localparam logic [WordW-1:0] InitSeed = 32'h0000_4321;

  typedef enum logic [1:0] {
    KIND_REINIT = 2'd0,
    KIND_SEED   = 2'd1,
    KIND_DRAW   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_MIX,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;    // add rotated seed into words 0 to 2
    logic load_clear; // clear all words first and use the initial seed
    logic mix_step;   // perform one mix update and rotate the ring
    logic out_load;   // capture the combined result in the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // output register may be loaded this cycle
  } dp_sts_t;

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] v,
                                              input int unsigned n);
    rotl32 = (v << n) | (v >> (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] xorshift(input logic [WordW-1:0] v);
    logic [WordW-1:0] t;
    t = v;
    t = t ^ (t >> 11);
    t = t ^ (t << 17);
    t = t ^ (t >> 13);
    xorshift = t;
  endfunction

endpackage

// ===== src/mixing_array_prng32_unit.sv =====
// Top level of the mixing-array 32-bit pseudo-random generator.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+----------------------------
//   input   | in        | in_valid_i / in_ready_o | kind_i, seed_word_i
//   output  | out       | out_valid_o/out_ready_i | random_value_o
//
// A draw is accepted, runs the mix chain and then combines the window into the
// output register. Seed and reinit items are accepted and run the mix chain;
// an unused kind is only accepted. The ten dependent mix updates, done one per
// cycle on a rotating ring of state words, make up the bulk of an item. After
// reset the block runs a reinit on its own and is not ready until it is done.
// A waiting result does not stop new items being accepted; a draw
// only stalls at its final step while the previous result is still untaken.
module mixing_array_prng32_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [maprng_pkg::WordW-1:0] seed_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [maprng_pkg::WordW-1:0] random_value_o
);
  import maprng_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // The controller owns sequencing and the step counter.
  maprng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // The datapath holds the state ring and the output register.
  maprng_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_word_i    (seed_word_i),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_value_o (random_value_o)
  );

  // No item is taken while the mix chain is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.mix_step |-> !in_ready_o)
    else $error("item accepted during mix");

  // An accepted draw starts the mix chain in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kind_i == KIND_DRAW) |=> dp_cmd.mix_step)
    else $error("draw did not start mixing");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten");

  // Seeding and mixing never happen in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_en |-> !dp_cmd.mix_step)
    else $error("load and mix together");

endmodule

// ===== src/maprng_ctrl.sv =====
// Controller state machine sequencing load, mix and output phases.
module maprng_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  maprng_pkg::dp_sts_t  sts_i,
  output maprng_pkg::dp_cmd_t  cmd_o
);
  import maprng_pkg::*;

  state_e              state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic                draw_q, draw_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      draw_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      draw_q  <= draw_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    draw_d     = draw_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        // The reset state is built by the same path as a reinit item.
        cmd_o.load_en    = 1'b1;
        cmd_o.load_clear = 1'b1;
        cnt_d            = '0;
        draw_d           = 1'b0;
        state_d          = ST_MIX;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_d = '0;
          case (kind_e'(kind_i))
            KIND_REINIT: begin
              cmd_o.load_en    = 1'b1;
              cmd_o.load_clear = 1'b1;
              draw_d           = 1'b0;
              state_d          = ST_MIX;
            end
            KIND_SEED: begin
              cmd_o.load_en = 1'b1;
              draw_d        = 1'b0;
              state_d       = ST_MIX;
            end
            KIND_DRAW: begin
              draw_d  = 1'b1;
              state_d = ST_MIX;
            end
            default: begin
              // Unused kind: the item is taken and dropped.
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MIX: begin
        cmd_o.mix_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == StepCntW'(MixSteps - 1)) begin
          state_d = draw_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/maprng_dp.sv =====
// Datapath: ring of state words, mix update, window combine and output register.
module maprng_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [maprng_pkg::WordW-1:0]    seed_word_i,
  input  maprng_pkg::dp_cmd_t             cmd_i,
  output maprng_pkg::dp_sts_t             sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [maprng_pkg::WordW-1:0]    random_value_o
);
  import maprng_pkg::*;

  logic [WordW-1:0]          ring_q [NumWords];
  logic [WordW-1:0]          ring_d [NumWords];
  logic [WordW-1:0]          out_q;
  logic                      out_valid_q;
  logic [WordW-1:0]          seed_val;
  logic [NumWords*WordW-1:0] flat;
  logic [3*WordW-1:0]        win;
  logic [WinSelW-1:0]        win_sel;
  logic [WordW-1:0]          mix_a, mix_b, mix_t, combined;

  assign seed_val = cmd_i.load_clear ? InitSeed : seed_word_i;

  always_comb begin
    ring_d = ring_q;
    if (cmd_i.load_en) begin
      if (cmd_i.load_clear) begin
        for (int i = 0; i < NumWords; i++) begin
          ring_d[i] = '0;
        end
      end
      ring_d[RingOfs]     = ring_d[RingOfs]     + rotl32(seed_val, 1);
      ring_d[RingOfs + 1] = ring_d[RingOfs + 1] + rotl32(seed_val, 12);
      ring_d[RingOfs + 2] = ring_d[RingOfs + 2] + rotl32(seed_val, 21);
    end else if (cmd_i.mix_step) begin
      // Position 0 is the target, 7 is three words back, 9 the previous one.
      for (int i = 0; i < NumWords - 1; i++) begin
        ring_d[i] = ring_q[i + 1];
      end
      ring_d[NumWords - 1] = (ring_q[0] + ring_q[RingOfs]) ^
                             rotl32(ring_q[NumWords - 1], 1);
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

  // Words laid out in natural order for the window read.
  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      flat[i*WordW +: WordW] = ring_q[(i + RingOfs) % NumWords];
    end
  end

  assign win_sel  = flat[(NumWords-1)*WordW +: WinSelW];
  assign win      = (3*WordW)'(flat >> {win_sel, 5'b00000});
  assign mix_a    = rotl32(win[0 +: WordW], 1);
  assign mix_b    = rotl32(win[WordW +: WordW], 12);
  assign mix_t    = xorshift(win[2*WordW +: WordW]);
  assign combined = (mix_a + mix_b) ^ mix_t;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= combined;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_q;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the mixing-array 32-bit pseudo-random generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import maprng_pkg::*;

  // The kind code that the block accepts and then ignores.
  localparam logic [1:0] KindUnused = 2'd3;

  // Cycles to let pass once the last result has arrived, so that a trailing
  // seed, reinit or stray result would still show up before the verdict.
  localparam int unsigned DrainCycles = 30;

  // Length of the long receiver hold-off used to fill the block up.
  localparam int unsigned HoldOffCycles = 400;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid    = 1'b0;
  logic [1:0]  kind_in     = KIND_DRAW;
  logic [31:0] seed_word   = '0;
  logic        out_ready   = 1'b0;
  logic        hold_off    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] random_value_o;

  // Idle probabilities, in percent per cycle, for each side of the block.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned error_count = 0;

  // Our own copy of the ten state words, and the draws still owed by the block.
  logic [31:0] prng_words [10];
  logic [31:0] expected_values [$];

  mixing_array_prng32_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_in),
    .seed_word_i   (seed_word),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .random_value_o(random_value_o)
  );

  // 2 ns clock.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // The chain of ten dependent updates. Each step folds in the value made three
  // steps earlier and the rotated value of the step just before, so the words
  // must be updated strictly in order: 3 to 9, then 0, 1 and 2 again.
  function automatic void mix_chain();
    logic [31:0] x [13];
    for (int i = 0; i < 3; i++) x[i] = prng_words[i];
    for (int k = 3; k < 13; k++) begin
      x[k] = (prng_words[k % 10] + x[k - 3]) ^ rol(x[k - 1], 1);
      prng_words[k % 10] = x[k];
    end
  endfunction

  function automatic void absorb_seed(input logic [31:0] word);
    prng_words[0] += rol(word, 1);
    prng_words[1] += rol(word, 12);
    prng_words[2] += rol(word, 21);
    mix_chain();
  endfunction

  // Reset and the reinit item both land here.
  function automatic void reseed_default();
    foreach (prng_words[i]) prng_words[i] = '0;
    absorb_seed(InitSeed);
  endfunction

  // A draw mixes first, then reads a window of three words whose start comes
  // from the low three bits of word 9. The start is at most 7, so the window
  // reaches word 9 at most.
  function automatic logic [31:0] draw_next();
    int unsigned start;
    logic [31:0] t;
    mix_chain();
    start = prng_words[9][2:0];
    t = prng_words[start + 2];
    t ^= t >> 11;
    t ^= t << 17;
    t ^= t >> 13;
    return (rol(prng_words[start], 1) + rol(prng_words[start + 1], 12)) ^ t;
  endfunction

  // Applies one accepted item to the predicted state. Only draws owe a result;
  // the unused kind leaves the state alone.
  function automatic void predict_item(input logic [1:0] kind, input logic [31:0] word);
    case (kind)
      KIND_REINIT: reseed_default();
      KIND_SEED:   absorb_seed(word);
      KIND_DRAW:   expected_values.push_back(draw_next());
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  // The ready line idles at random, and stays low for the whole of a hold-off.
  always @(posedge clk_i) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Every result taken is checked against the oldest draw still owed.
  always @(posedge clk_i) begin : check_results
    logic [31:0] want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_values.size() == 0) begin
        $error("random_value: no result expected, actual %08h", random_value_o);
        error_count++;
      end else begin
        want = expected_values.pop_front();
        if (random_value_o !== want) begin
          $error("random_value: expected %08h, actual %08h", want, random_value_o);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one item and waits for it to be taken. It is always entered just
  // after a rising edge. Valid is only lowered for an idle gap, so back-to-back
  // items keep it high without a glitch.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    kind_in   <= kind;
    seed_word <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_item(kind, word);
  endtask

  // Seed words lean on full random values, with the all-zero, all-one and
  // single-bit patterns mixed in now and then.
  function automatic logic [31:0] pick_seed_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Draws straight after reset show that the block seeds itself on reset.
  task automatic test_reset_state();
    send_item(KIND_DRAW, '0);
    send_item(KIND_DRAW, '1);
  endtask

  // Extreme seed words, the ignored kind, and a reinit returning the generator
  // to its reset sequence.
  task automatic test_directed();
    send_item(KIND_SEED, 32'h0000_0000);
    send_item(KIND_DRAW, '0);
    send_item(KIND_SEED, 32'hFFFF_FFFF);
    send_item(KIND_DRAW, '0);
    send_item(KIND_SEED, 32'h8000_0000);
    send_item(KIND_DRAW, '0);
    send_item(KIND_SEED, 32'h0000_0001);
    send_item(KIND_DRAW, '0);
    send_item(KindUnused, 32'hFFFF_FFFF);
    send_item(KindUnused, 32'h0000_0000);
    send_item(KIND_DRAW, '0);
    send_item(KIND_REINIT, 32'hFFFF_FFFF);
    send_item(KIND_DRAW, '0);
    send_item(KIND_DRAW, '0);
    send_item(KIND_SEED, 32'hA5A5_A5A5);
    send_item(KIND_SEED, 32'h5A5A_5A5A);
    send_item(KIND_REINIT, 32'h0000_0000);
    send_item(KIND_SEED, 32'h1234_5678);
    send_item(KIND_DRAW, '0);
    send_item(KIND_DRAW, '0);
  endtask

  // Mostly draws, with seeds in between and the odd reinit. Ignored items are
  // sprinkled in but do not count towards the total.
  task automatic test_random(input int unsigned count);
    int unsigned done;
    int unsigned roll;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        send_item(KIND_REINIT, $urandom());
        done++;
      end else if (roll < 26) begin
        send_item(KIND_SEED, pick_seed_word());
        done++;
      end else if (roll < 95) begin
        send_item(KIND_DRAW, $urandom());
        done++;
      end else begin
        send_item(KindUnused, $urandom());
      end
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // draws, so a result sits untaken and the block has to stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) begin
      if (i % 5 == 4) send_item(KIND_SEED, $urandom());
      else send_item(KIND_DRAW, $urandom());
    end
  endtask

  initial begin
    reseed_default();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_directed();
    test_backpressure();

    // Sender idles lightly and the receiver heavily, then the other way round,
    // and finally both run flat out.
    send_idle_pct = 19;
    recv_idle_pct = 57;
    test_random(530);
    send_idle_pct = 57;
    recv_idle_pct = 19;
    test_random(530);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(530);

    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // A hang anywhere ends the run here.
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
src/maprng_pkg.sv
src/maprng_ctrl.sv
src/maprng_dp.sv
src/mixing_array_prng32_unit.sv
tb/testbench.sv
